### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl modules
// depends on nothing; the using module supplies clock and reset signals
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define CHK_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every clock edge, reset included
`define CHK_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/clcd_pkg.sv
// types, control store and helper functions of the character display writer
// no dependencies
package clcd_pkg;

   localparam int PcWidth = 6;
   typedef logic [PcWidth-1:0] pc_type;

   // operation codes of the request beat
   typedef enum logic [3:0] {
      OP_CHAR      = 4'd0,
      OP_INIT      = 4'd1,
      OP_CLEAR     = 4'd2,
      OP_HOME      = 4'd3,
      OP_ENTRY     = 4'd4,
      OP_DISPCTL   = 4'd5,
      OP_SHIFT     = 4'd6,
      OP_SETPOS    = 4'd7,
      OP_BACKLIGHT = 4'd8,
      OP_SELGLYPH  = 4'd9,
      OP_GLYPHDATA = 4'd10
   } op_type;

   // register indexes of the csr channel
   typedef enum logic [2:0] {
      REG_ROW_COUNT = 3'd0,
      REG_COL_COUNT = 3'd1,
      REG_ROW_BASE0 = 3'd2,
      REG_ROW_BASE1 = 3'd3,
      REG_ROW_BASE2 = 3'd4,
      REG_ROW_BASE3 = 3'd5
   } reg_type;

   typedef enum logic [1:0] {
      EM_NONE,
      EM_NIB,
      EM_BYTE
   } emit_type;

   typedef enum logic [2:0] {
      SRC_CONST,
      SRC_VALUE,
      SRC_ADDR,
      SRC_ENTRY,
      SRC_DISP,
      SRC_SHIFT,
      SRC_GSEL
   } src_type;

   typedef enum logic [3:0] {
      EF_NONE,
      EF_CLRPEND,
      EF_COLSTEP,
      EF_COLZERO,
      EF_ROWLF,
      EF_INCSET,
      EF_INCONE,
      EF_CURZERO,
      EF_CURLOAD,
      EF_BACKLIGHT,
      EF_GSEL,
      EF_GCOUNT
   } eff_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_JUMP,
      CND_OOB,
      CND_NOPEND,
      CND_CNTNE8,
      CND_CHARDISP,
      CND_END
   } cond_type;

   typedef struct packed {
      emit_type   emit;
      src_type    src;
      logic       rs;
      logic [7:0] konst;
      eff_type    eff;
      cond_type   cond;
      pc_type     target;
   } ucode_type;

   // program entry points
   localparam pc_type PC_END      = 6'd0;
   localparam pc_type PC_CHARPEND = 6'd1;
   localparam pc_type PC_CR       = 6'd3;
   localparam pc_type PC_LF       = 6'd4;
   localparam pc_type PC_TAB      = 6'd5;
   localparam pc_type PC_TAB2     = 6'd7;
   localparam pc_type PC_CHR      = 6'd9;
   localparam pc_type PC_INIT     = 6'd11;
   localparam pc_type PC_MOVE00   = 6'd20;
   localparam pc_type PC_MOVECHK  = 6'd21;
   localparam pc_type PC_CLEAR    = 6'd23;
   localparam pc_type PC_HOME     = 6'd24;
   localparam pc_type PC_ENTRY    = 6'd25;
   localparam pc_type PC_DISP     = 6'd26;
   localparam pc_type PC_SHIFT    = 6'd27;
   localparam pc_type PC_SETPOS   = 6'd28;
   localparam pc_type PC_BACKLT   = 6'd29;
   localparam pc_type PC_GSEL     = 6'd30;
   localparam pc_type PC_GDATA    = 6'd31;
   localparam pc_type PC_COUNT    = 6'd35;

   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChSpace = 8'h20;

   // control store: one word per step
   function automatic ucode_type clcd_ucode(input pc_type pc);
      ucode_type w;
      w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_END, PC_END};
      unique case (pc)
         6'd0:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_END, PC_END};
         // char with a glyph pending: move back to the cursor first
         6'd1:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_OOB, PC_END};
         6'd2:  w = '{EM_BYTE, SRC_ADDR, 1'b0, 8'h00, EF_CLRPEND, CND_CHARDISP, PC_END};
         6'd3:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_COLZERO, CND_END, PC_END};
         6'd4:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_ROWLF, CND_END, PC_END};
         // tab: two spaces, each bounds checked
         6'd5:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_OOB, PC_TAB2};
         6'd6:  w = '{EM_BYTE, SRC_CONST, 1'b1, ChSpace, EF_COLSTEP, CND_NEXT, PC_END};
         6'd7:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_OOB, PC_END};
         6'd8:  w = '{EM_BYTE, SRC_CONST, 1'b1, ChSpace, EF_COLSTEP, CND_JUMP, PC_END};
         6'd9:  w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_OOB, PC_END};
         6'd10: w = '{EM_BYTE, SRC_VALUE, 1'b1, 8'h00, EF_COLSTEP, CND_JUMP, PC_END};
         // init sequence
         6'd11: w = '{EM_NIB, SRC_CONST, 1'b0, 8'h03, EF_NONE, CND_NEXT, PC_END};
         6'd12: w = '{EM_NIB, SRC_CONST, 1'b0, 8'h03, EF_NONE, CND_NEXT, PC_END};
         6'd13: w = '{EM_NIB, SRC_CONST, 1'b0, 8'h03, EF_NONE, CND_NEXT, PC_END};
         6'd14: w = '{EM_NIB, SRC_CONST, 1'b0, 8'h02, EF_NONE, CND_NEXT, PC_END};
         6'd15: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h28, EF_NONE, CND_NEXT, PC_END};
         6'd16: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h08, EF_NONE, CND_NEXT, PC_END};
         6'd17: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h01, EF_NONE, CND_NEXT, PC_END};
         6'd18: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h06, EF_INCONE, CND_NEXT, PC_END};
         6'd19: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h0C, EF_NONE, CND_NEXT, PC_END};
         // move to the cursor position, shared by init, clear and set position
         6'd20: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_CURZERO, CND_NEXT, PC_END};
         6'd21: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_OOB, PC_END};
         6'd22: w = '{EM_BYTE, SRC_ADDR, 1'b0, 8'h00, EF_NONE, CND_JUMP, PC_END};
         6'd23: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h01, EF_NONE, CND_JUMP, PC_MOVE00};
         6'd24: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h02, EF_NONE, CND_JUMP, PC_END};
         6'd25: w = '{EM_BYTE, SRC_ENTRY, 1'b0, 8'h00, EF_INCSET, CND_JUMP, PC_END};
         6'd26: w = '{EM_BYTE, SRC_DISP, 1'b0, 8'h00, EF_NONE, CND_JUMP, PC_END};
         6'd27: w = '{EM_BYTE, SRC_SHIFT, 1'b0, 8'h00, EF_NONE, CND_JUMP, PC_END};
         6'd28: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_CURLOAD, CND_JUMP, PC_MOVECHK};
         6'd29: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_BACKLIGHT, CND_END, PC_END};
         6'd30: w = '{EM_BYTE, SRC_GSEL, 1'b0, 8'h00, EF_GSEL, CND_JUMP, PC_END};
         // glyph row data
         6'd31: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_NOPEND, PC_END};
         6'd32: w = '{EM_BYTE, SRC_VALUE, 1'b1, 8'h00, EF_GCOUNT, CND_NEXT, PC_END};
         6'd33: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_CNTNE8, PC_END};
         6'd34: w = '{EM_BYTE, SRC_CONST, 1'b0, 8'h80, EF_CLRPEND, CND_JUMP, PC_END};
         default: w = '{EM_NONE, SRC_CONST, 1'b0, 8'h00, EF_NONE, CND_END, PC_END};
      endcase
      return w;
   endfunction

   // first step for a character, by its code
   function automatic pc_type clcd_char_entry(input logic [7:0] ch);
      pc_type p;
      if (ch == ChCr) begin
         p = PC_CR;
      end else if (ch == ChLf) begin
         p = PC_LF;
      end else if (ch == ChTab) begin
         p = PC_TAB;
      end else begin
         p = PC_CHR;
      end
      return p;
   endfunction

   // first step for an accepted request
   function automatic pc_type clcd_entry(input logic [3:0] op, input logic pend,
                                         input logic [7:0] ch);
      pc_type p;
      unique case (op)
         OP_CHAR:      p = pend ? PC_CHARPEND : clcd_char_entry(ch);
         OP_INIT:      p = PC_INIT;
         OP_CLEAR:     p = PC_CLEAR;
         OP_HOME:      p = PC_HOME;
         OP_ENTRY:     p = PC_ENTRY;
         OP_DISPCTL:   p = PC_DISP;
         OP_SHIFT:     p = PC_SHIFT;
         OP_SETPOS:    p = PC_SETPOS;
         OP_BACKLIGHT: p = PC_BACKLT;
         OP_SELGLYPH:  p = PC_GSEL;
         OP_GLYPHDATA: p = PC_GDATA;
         default:      p = PC_END;
      endcase
      return p;
   endfunction

   // remainder by three of a 9-bit value via base-4 digit sums
   function automatic logic [1:0] clcd_mod3(input logic [8:0] x);
      logic [3:0] s;
      logic [2:0] t;
      s = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]} + {2'b00, x[7:6]}
          + {3'b000, x[8]};
      t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
      if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      if (t == 3'd3) begin
         t = 3'd0;
      end
      return t[1:0];
   endfunction

endpackage

### rtl/core/char_lcd_command_nibble_writer.sv
// character display writer top level: microcoded sequencer and port byte datapath
// depends on clcd_pkg and assert_macros.svh
//
// usage
// - req channel: one beat per character or command; tuser carries the operation,
//   tdata the value, target row, target column and backlight level
// - rsp channel: one beat per port write to the display; tdata is the port byte,
//   tlast marks the final write caused by a request (requests with no writes
//   give no beats)
// - csr channel: register writes, taken any cycle, meant for idle periods only
// - a request gives one port write per cycle while the rsp side does not stall,
//   and each control step that writes nothing adds to its run; the single
//   write-per-cycle emit path of the sequencer sets that rate
// - each write first goes to a hold register and moves to the output register
//   when the next write or the end of the program pushes it out: one write is
//   held back so that tlast can be set once the program ends
// - req_tready stays low while a program runs; a new request is taken the
//   cycle after the last write has moved to the output register
// - a stalled rsp side freezes the sequencer at its next write or end step,
//   with the beat held in place; reset: cursor 0,0, increment mode, backlight
//   on, no glyph pending, 4 rows by 20 columns with row bases 0, 64, 20, 84
`include "assert_macros.svh"

module char_lcd_command_nibble_writer
   import clcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[7:0], row[15:8], col[23:16], level[31:24]
   input  logic [3:0]  req_tuser,   // operation[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // port_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // config registers
   logic [2:0] row_count_ff, row_count_in;
   logic [5:0] col_count_ff, col_count_in;
   logic [6:0] row_base_ff [4];
   logic [6:0] row_base_in [4];

   // display state
   logic [7:0] cur_row_ff, cur_row_in;
   logic [7:0] cur_col_ff, cur_col_in;
   logic       inc_mode_ff, inc_mode_in;
   logic       backlight_ff, backlight_in;
   logic       glyph_pend_ff, glyph_pend_in;
   logic [3:0] glyph_cnt_ff, glyph_cnt_in;

   // sequencer
   logic       busy_ff, busy_in;
   pc_type     pc_ff, pc_in;
   logic [2:0] wcnt_ff, wcnt_in;

   // latched request fields
   logic [7:0] value_ff, value_in;
   logic [7:0] tgt_row_ff, tgt_row_in;
   logic [7:0] tgt_col_ff, tgt_col_in;
   logic [7:0] level_ff, level_in;

   // held write and output register
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   ucode_type  uw;
   logic [2:0] eff_rows;
   logic       in_bounds;
   logic [7:0] addr_byte;
   logic [7:0] src_byte;
   logic [3:0] nib;
   logic       enable_bit;
   logic [7:0] wr_byte;
   logic       out_free;
   logic       emitting;
   logic       stall;
   logic       step_done;
   logic [2:0] last_wcnt;
   logic [8:0] row_plus;
   logic [7:0] lf_row;
   logic       req_accept;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && !busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      uw        = clcd_ucode(pc_ff);
      eff_rows  = (row_count_ff > 3'd4) ? 3'd4 : row_count_ff;
      in_bounds = (cur_row_ff < {5'd0, eff_rows}) && (cur_col_ff < {2'd0, col_count_ff});
      // set address command for the cursor, wrapping inside display memory
      addr_byte = {1'b1, row_base_ff[cur_row_ff[1:0]] + cur_col_ff[6:0]};

      unique case (uw.src)
         SRC_CONST: src_byte = uw.konst;
         SRC_VALUE: src_byte = value_ff;
         SRC_ADDR:  src_byte = addr_byte;
         SRC_ENTRY: src_byte = {6'b000001, value_ff[1:0]};
         SRC_DISP:  src_byte = {5'b00001, value_ff[2:0]};
         SRC_SHIFT: src_byte = {4'b0001, value_ff[2], value_ff[1], 2'b00};
         SRC_GSEL:  src_byte = {2'b01, value_ff[2:0], 3'b000};
         default:   src_byte = uw.konst;
      endcase

      // byte: high nibble in writes 0..2, low nibble in writes 3..5
      if (uw.emit == EM_NIB) begin
         nib       = uw.konst[3:0];
         last_wcnt = 3'd2;
      end else begin
         nib       = (wcnt_ff < 3'd3) ? src_byte[7:4] : src_byte[3:0];
         last_wcnt = 3'd5;
      end
      enable_bit = (wcnt_ff == 3'd1) || (wcnt_ff == 3'd4);
      wr_byte    = {nib, backlight_ff, enable_bit, 1'b0, uw.rs};

      out_free  = !rsp_valid_ff || rsp_tready;
      emitting  = busy_ff && (uw.emit != EM_NONE);
      stall     = busy_ff && ((uw.emit != EM_NONE) || (uw.cond == CND_END))
                  && hold_valid_ff && !out_free;
      step_done = busy_ff && !stall && ((uw.emit == EM_NONE) || (wcnt_ff == last_wcnt));

      // line feed: next row modulo the rows in use
      row_plus = {1'b0, cur_row_ff} + 9'd1;
      unique case (eff_rows)
         3'd2:    lf_row = {7'd0, row_plus[0]};
         3'd3:    lf_row = {6'd0, clcd_mod3(row_plus)};
         3'd4:    lf_row = {6'd0, row_plus[1:0]};
         default: lf_row = 8'd0;
      endcase
   end

   // sequencer, effects and output staging
   always_comb begin
      busy_in       = busy_ff;
      pc_in         = pc_ff;
      wcnt_in       = wcnt_ff;
      value_in      = value_ff;
      tgt_row_in    = tgt_row_ff;
      tgt_col_in    = tgt_col_ff;
      level_in      = level_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      inc_mode_in   = inc_mode_ff;
      backlight_in  = backlight_ff;
      glyph_pend_in = glyph_pend_ff;
      glyph_cnt_in  = glyph_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_accept) begin
         busy_in    = 1'b1;
         pc_in      = clcd_entry(req_tuser, glyph_pend_ff, req_tdata[7:0]);
         wcnt_in    = 3'd0;
         value_in   = req_tdata[7:0];
         tgt_row_in = req_tdata[15:8];
         tgt_col_in = req_tdata[23:16];
         level_in   = req_tdata[31:24];
      end

      // a new write pushes the held one out, not marked last
      if (emitting && !stall) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = hold_byte_ff;
            rsp_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_byte_in  = wr_byte;
      end

      if (busy_ff && !stall) begin
         wcnt_in = step_done ? 3'd0 : wcnt_ff + 3'd1;
      end

      if (step_done) begin
         unique case (uw.eff)
            EF_NONE:      ;
            EF_CLRPEND:   glyph_pend_in = 1'b0;
            EF_COLSTEP:   cur_col_in = inc_mode_ff ? cur_col_ff + 8'd1 : cur_col_ff - 8'd1;
            EF_COLZERO:   cur_col_in = 8'd0;
            EF_ROWLF:     cur_row_in = lf_row;
            EF_INCSET:    inc_mode_in = value_ff[1];
            EF_INCONE:    inc_mode_in = 1'b1;
            EF_CURZERO: begin
               cur_row_in = 8'd0;
               cur_col_in = 8'd0;
            end
            EF_CURLOAD: begin
               cur_row_in = tgt_row_ff;
               cur_col_in = tgt_col_ff;
            end
            EF_BACKLIGHT: begin
               if (value_ff == 8'd1) begin
                  backlight_in = (level_ff != 8'd0);
               end
            end
            EF_GSEL: begin
               glyph_pend_in = 1'b1;
               glyph_cnt_in  = 4'd0;
            end
            EF_GCOUNT:    glyph_cnt_in = glyph_cnt_ff + 4'd1;
            default:      ;
         endcase

         unique case (uw.cond)
            CND_NEXT:     pc_in = pc_ff + 6'd1;
            CND_JUMP:     pc_in = uw.target;
            CND_OOB:      pc_in = in_bounds ? pc_ff + 6'd1 : uw.target;
            CND_NOPEND:   pc_in = glyph_pend_ff ? pc_ff + 6'd1 : uw.target;
            CND_CNTNE8:   pc_in = (glyph_cnt_ff != 4'd8) ? uw.target : pc_ff + 6'd1;
            CND_CHARDISP: pc_in = clcd_char_entry(value_ff);
            CND_END: begin
               // flush the held write as the last beat of this request
               busy_in = 1'b0;
               if (hold_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = hold_byte_ff;
                  rsp_last_in   = 1'b1;
                  hold_valid_in = 1'b0;
               end
            end
            default:      pc_in = PC_END;
         endcase
      end
   end

   // csr writes
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      row_base_in  = row_base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_COUNT: row_count_in   = csr_data[2:0];
            REG_COL_COUNT: col_count_in   = csr_data[5:0];
            REG_ROW_BASE0: row_base_in[0] = csr_data[6:0];
            REG_ROW_BASE1: row_base_in[1] = csr_data[6:0];
            REG_ROW_BASE2: row_base_in[2] = csr_data[6:0];
            REG_ROW_BASE3: row_base_in[3] = csr_data[6:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pc_ff         <= PC_END;
         wcnt_ff       <= 3'd0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cur_row_ff    <= 8'd0;
         cur_col_ff    <= 8'd0;
         inc_mode_ff   <= 1'b1;
         backlight_ff  <= 1'b1;
         glyph_pend_ff <= 1'b0;
         glyph_cnt_ff  <= 4'd0;
         row_count_ff  <= 3'd4;
         col_count_ff  <= 6'd20;
         row_base_ff   <= '{7'd0, 7'd64, 7'd20, 7'd84};
      end else begin
         busy_ff       <= busy_in;
         pc_ff         <= pc_in;
         wcnt_ff       <= wcnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         inc_mode_ff   <= inc_mode_in;
         backlight_ff  <= backlight_in;
         glyph_pend_ff <= glyph_pend_in;
         glyph_cnt_ff  <= glyph_cnt_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         row_base_ff   <= row_base_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      tgt_row_ff   <= tgt_row_in;
      tgt_col_ff   <= tgt_col_in;
      level_ff     <= level_in;
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // a held write never outlives its program
   `CHK_RUN(a_hold_only_busy, !busy_ff |-> !hold_valid_ff, "held write while idle")
   // write counter stays inside one byte
   `CHK_RUN(a_wcnt_range, wcnt_ff <= 3'd5, "write counter out of range")
   // step counter stays inside the control store
   `CHK_RUN(a_pc_range, pc_ff < PC_COUNT, "step counter outside control store")
   // glyph rows never run past eight
   `CHK_RUN(a_glyph_cnt, glyph_cnt_ff <= 4'd8, "glyph row count above eight")
   // reset leaves the sequencer idle
   `CHK_ALL(a_reset_idle, reset |=> !busy_ff && !rsp_valid_ff, "busy after reset")

endmodule
